// ===== hdl/pidc_pkg.sv =====
// Shared types, constants and helpers for the clamped-integral PID step.
// No dependencies.
`default_nettype none
package pidc_pkg;
	localparam int W = 24;
	localparam int FRAC = 6;
	localparam int DECAY = 1;
	localparam int DTW = 23;
	localparam int PW = 2 * W;
	localparam int QW = PW + 2;
	localparam int QCW = $clog2(QW + 1);

	localparam logic [2:0] REG_SETPOINT = 3'd0;
	localparam logic [2:0] REG_GAIN_P = 3'd1;
	localparam logic [2:0] REG_GAIN_I = 3'd2;
	localparam logic [2:0] REG_GAIN_D = 3'd3;
	localparam logic [2:0] REG_INT_LOW = 3'd4;
	localparam logic [2:0] REG_INT_HIGH = 3'd5;
	localparam logic [2:0] REG_OUT_LOW = 3'd6;
	localparam logic [2:0] REG_OUT_HIGH = 3'd7;

	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// datapath commands
	typedef struct packed {
		logic load;
		logic err;
		logic mul_p;
		logic mul_i1;
		logic mul_i2;
		logic int_upd;
		logic div_start;
		logic div_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	// saturate a wide signed value to the word
	function automatic logic signed [W-1:0] sat(input logic signed [QW-1:0] v);
		logic signed [W-1:0] r;
		if (v > QW'(signed'(WMAX))) r = WMAX;
		else if (v < QW'(signed'(WMIN))) r = WMIN;
		else r = v[W-1:0];
		return r;
	endfunction

	function automatic logic signed [W-1:0] clampv(input logic signed [W-1:0] x,
			input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
		logic signed [W-1:0] r;
		if (x < lo) r = lo;
		else if (x > hi) r = hi;
		else r = x;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/pidc_datapath.sv =====
// PID datapath: registers, a shared P/I multiplier, a derivative-gain multiplier and a restoring divider.
// Depends on pidc_pkg.
`default_nettype none
module pidc_datapath import pidc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [W-1:0] cfg_data,
	input wire logic [DTW-1:0] in_dt,
	input wire logic signed [W-1:0] in_meas,
	input wire logic in_clr,
	input wire cmd_t cmd,
	output sts_t sts,
	output logic signed [W-1:0] drive_q
);
	logic signed [W-1:0] setpoint_q, kp_q, ki_q, kd_q, il_q, ih_q, ol_q, oh_q;
	logic signed [W-1:0] iacc_q, lerr_q;
	logic [DTW-1:0] dt_q;
	logic signed [W-1:0] meas_q, e_q, p_q, t_q;
	logic clr_q;
	logic signed [W:0] ma, mb;
	logic signed [PW+1:0] prod;
	logic signed [QW-1:0] rnd;
	logic signed [W-1:0] mres;
	// divider state
	logic [QW-1:0] rem_q, quo_q, num_abs;
	logic neg_q;
	logic [QCW-1:0] cnt_q;
	logic signed [QW-1:0] num, q_s;
	logic [QW-1:0] rtry;
	logic signed [W-1:0] de, d_v;

	// shared multiplier operand select
	always_comb begin
		ma = (W+1)'(signed'(e_q));
		mb = (W+1)'(signed'(kp_q));
		if (cmd.mul_i1) mb = (W+1)'(signed'(ki_q));
		if (cmd.mul_i2) begin
			ma = (W+1)'(signed'(t_q));
			mb = signed'({2'b00, dt_q});
		end
		prod = (PW+2)'(ma) * (PW+2)'(mb);
		rnd = QW'(prod) + ((FRAC > 0) ? (QW'(1) <<< (FRAC > 0 ? FRAC - 1 : 0)) : QW'(0));
		mres = sat(rnd >>> FRAC);
	end

	assign de = sat(QW'(e_q) - QW'(lerr_q));
	assign num = QW'(de) * QW'(kd_q) + QW'(dt_q >> 1);
	assign num_abs = num[QW-1] ? QW'(-num) : QW'(num);
	assign rtry = {rem_q[QW-2:0], quo_q[QW-1]};
	assign q_s = neg_q ? -signed'(quo_q) : signed'(quo_q);
	assign d_v = (dt_q == '0) ? '0 : sat(q_s);
	assign sts.div_done = (cnt_q == '0);

	// configuration and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0; kp_q <= '0; ki_q <= '0; kd_q <= '0;
			il_q <= WMIN; ih_q <= WMAX; ol_q <= WMIN; oh_q <= WMAX;
			iacc_q <= '0; lerr_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SETPOINT: setpoint_q <= cfg_data;
					REG_GAIN_P: kp_q <= cfg_data;
					REG_GAIN_I: ki_q <= cfg_data;
					REG_GAIN_D: kd_q <= cfg_data;
					REG_INT_LOW: il_q <= cfg_data;
					REG_INT_HIGH: ih_q <= cfg_data;
					REG_OUT_LOW: ol_q <= cfg_data;
					REG_OUT_HIGH: oh_q <= cfg_data;
				endcase
				if (cfg_idx == REG_GAIN_P || cfg_idx == REG_GAIN_I || cfg_idx == REG_GAIN_D) begin
					iacc_q <= '0; lerr_q <= '0;
				end
			end
			if (cmd.err && clr_q) begin
				iacc_q <= '0; lerr_q <= '0;
			end
			if (cmd.int_upd)
				iacc_q <= clampv(sat(QW'(iacc_q) + QW'(mres)), il_q, ih_q);
			if (cmd.div_start) begin
				cnt_q <= QCW'(QW);
				// decay: (2e+D)/(2D), truncated toward zero
				lerr_q <= sat(QW'((QW'(2) * QW'(e_q) + QW'(DECAY)) / QW'(2 * DECAY)));
			end else if (cmd.div_step && cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dt_q <= in_dt; meas_q <= in_meas; clr_q <= in_clr;
		end
		if (cmd.err) e_q <= sat(QW'(setpoint_q) - QW'(meas_q));
		if (cmd.mul_p) p_q <= mres;
		if (cmd.mul_i1) t_q <= mres;
		if (cmd.div_start) begin
			rem_q <= '0; quo_q <= num_abs; neg_q <= num[QW-1];
		end else if (cmd.div_step && cnt_q != '0) begin
			if (rtry >= QW'(dt_q)) begin
				rem_q <= rtry - QW'(dt_q);
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.fin)
			drive_q <= clampv(sat(QW'(sat(QW'(p_q) + QW'(iacc_q))) + QW'(d_v)), ol_q, oh_q);
	end
endmodule
`default_nettype wire

// ===== hdl/pidc_ctrl.sv =====
// PID step sequencer and handshake control.
// Depends on pidc_pkg.
`default_nettype none
module pidc_ctrl import pidc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire sts_t sts,
	output cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0, S_ERR = 3'd1, S_MP = 3'd2, S_MI1 = 3'd3,
		S_MI2 = 3'd4, S_DIV = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;
	logic [2:0] state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.err = (state_q == S_ERR);
		cmd.mul_p = (state_q == S_MP);
		cmd.mul_i1 = (state_q == S_MI1);
		cmd.mul_i2 = (state_q == S_MI2);
		cmd.int_upd = (state_q == S_MI2);
		cmd.div_start = (state_q == S_MI2);
		cmd.div_step = (state_q == S_DIV);
		cmd.fin = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_ERR;
				S_ERR: state_q <= S_MP;
				S_MP: state_q <= S_MI1;
				S_MI1: state_q <= S_MI2;
				S_MI2: state_q <= S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/pid_step_clamped_integral.sv =====
// PID step with clamped integral: top level joining sequencer and datapath.
// Sequenced from input transfer through error, P, I and derivative steps to the result;
// one item at a time, paced by the 50-step restoring divider and held until accepted.
// Reset (arst_n low) restores register defaults and zeroes integral and last error.
// Depends on pidc_pkg, pidc_ctrl, pidc_datapath.
`default_nettype none
module pid_step_clamped_integral import pidc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [47:0] s_tdata, // time_step[22:0], measured[46:23], pad
	input wire logic s_tuser, // clear_state
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata, // drive[23:0]
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [23:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic signed [W-1:0] drive;

	pidc_ctrl u_ctrl (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .sts, .cmd);
	pidc_datapath u_dp (.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_dt(s_tdata[22:0]), .in_meas(s_tdata[46:23]), .in_clr(s_tuser),
		.cmd, .sts, .drive_q(drive));
	assign m_tdata = drive;
endmodule
`default_nettype wire

// ===== hdl/pidc_checker.sv =====
// Port-level checker for the PID step, bound to the top level.
// Depends on pid_step_clamped_integral.
`default_nettype none
module pidc_port_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [23:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken with result pending");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule
bind pid_step_clamped_integral pidc_port_props u_chk (.clk, .arst_n, .s_tvalid, .s_tready,
	.m_tvalid, .m_tready, .m_tdata);
`default_nettype wire
